[design/reservation_station_unit_macros.svh]
// assertion helpers for the reservation station
`ifndef RESERVATION_STATION_UNIT_MACROS_SVH
`define RESERVATION_STATION_UNIT_MACROS_SVH

// same-cycle implication
`define RSU_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rsu_pkg.sv]
package rsu_pkg;

  localparam int RSU_ENTRIES = 8;
  localparam int W_VAL       = 32;
  localparam int W_ROB_IN    = 6;
  localparam int W_ROB       = 7;
  localparam int W_FREE      = 4;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_BCAST = 2'd1,
    CMD_DISP  = 2'd2,
    CMD_SHIFT = 2'd3
  } cmd_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic [W_ROB-1:0] rob;
    logic [W_VAL-1:0] first;
    logic [W_VAL-1:0] second;
    logic             writes;
    logic [W_VAL-1:0] dest;
    logic             branch;
    logic [W_VAL-1:0] pc;
  } slot_t;

  typedef struct packed {
    logic                apply;
    cmd_t                cmd;
    logic                emit_mode;
    logic [W_VAL-1:0]    first_operand;
    logic                first_ready;
    logic [W_VAL-1:0]    second_operand;
    logic                second_ready;
    logic [W_VAL-1:0]    pc;
    logic [W_ROB_IN-1:0] rob_slot;
    logic                writes_reg;
    logic                is_branch;
    logic [W_VAL-1:0]    dest_rename;
    logic [W_VAL-1:0]    bcast_tag;
    logic [W_VAL-1:0]    bcast_value;
  } cell_ctl_t;

  typedef struct packed {
    logic busy;
    logic pend;
  } cell_st_t;

endpackage

[design/rsu_cell.sv]
module rsu_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rsu_pkg::cell_ctl_t ctl,
  input  logic              take,
  input  logic              claim_in,
  output logic              claim_out,
  output logic              grant,
  output rsu_pkg::cell_st_t st,
  output rsu_pkg::slot_t    data
);
  import rsu_pkg::*;

  logic             busy_r, busy_nxt;
  logic             pend_r, pend_nxt;
  logic             f_ok_r, f_ok_nxt;
  logic             s_ok_r, s_ok_nxt;
  logic [W_VAL-1:0] f_val_r, f_val_nxt;
  logic [W_VAL-1:0] s_val_r, s_val_nxt;
  logic [W_VAL-1:0] pc_r, pc_nxt;
  logic [W_ROB-1:0] rob_r, rob_nxt;
  logic [W_VAL-1:0] dest_r, dest_nxt;
  logic             wr_r, wr_nxt;
  logic             br_r, br_nxt;
  logic             cand;
  logic             ready;

  // priority chain: lowest free slot for allocate, lowest pending slot for emit
  assign cand      = ctl.emit_mode ? pend_r : !busy_r;
  assign grant     = cand && !claim_in;
  assign claim_out = claim_in || cand;
  assign ready     = busy_r && f_ok_r && s_ok_r;

  always_comb begin
    busy_nxt  = busy_r;
    pend_nxt  = pend_r;
    f_ok_nxt  = f_ok_r;
    s_ok_nxt  = s_ok_r;
    f_val_nxt = f_val_r;
    s_val_nxt = s_val_r;
    pc_nxt    = pc_r;
    rob_nxt   = rob_r;
    dest_nxt  = dest_r;
    wr_nxt    = wr_r;
    br_nxt    = br_r;
    if (ctl.apply) begin
      case (ctl.cmd)
        CMD_ALLOC: begin
          if (grant) begin
            busy_nxt  = 1'b1;
            f_val_nxt = ctl.first_operand;
            f_ok_nxt  = ctl.first_ready;
            s_val_nxt = ctl.second_operand;
            s_ok_nxt  = ctl.second_ready;
            pc_nxt    = ctl.pc;
            rob_nxt   = {1'b0, ctl.rob_slot};
            wr_nxt    = ctl.writes_reg;
            br_nxt    = ctl.is_branch;
            dest_nxt  = ctl.writes_reg ? ctl.dest_rename : '0;
          end
        end
        CMD_BCAST: begin
          if (busy_r) begin
            if (!f_ok_r && f_val_r == ctl.bcast_tag) begin
              f_val_nxt = ctl.bcast_value;
              f_ok_nxt  = 1'b1;
            end
            if (!s_ok_r && s_val_r == ctl.bcast_tag) begin
              s_val_nxt = ctl.bcast_value;
              s_ok_nxt  = 1'b1;
            end
          end
        end
        CMD_DISP: begin
          if (ready) begin
            busy_nxt = 1'b0;
            pend_nxt = 1'b1;
          end
        end
        CMD_SHIFT: begin
          if (busy_r) begin
            rob_nxt  = rob_r - W_ROB'(1);
            dest_nxt = dest_r - W_VAL'(1);
            if (!f_ok_r) f_val_nxt = f_val_r - W_VAL'(1);
            if (!s_ok_r) s_val_nxt = s_val_r - W_VAL'(1);
          end
        end
        default: begin
          busy_nxt = busy_r;
        end
      endcase
    end
    if (take && grant) pend_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_ok_r  <= f_ok_nxt;
    s_ok_r  <= s_ok_nxt;
    f_val_r <= f_val_nxt;
    s_val_r <= s_val_nxt;
    pc_r    <= pc_nxt;
    rob_r   <= rob_nxt;
    dest_r  <= dest_nxt;
    wr_r    <= wr_nxt;
    br_r    <= br_nxt;
  end

  assign st.busy     = busy_r;
  assign st.pend     = pend_r;
  assign data.rob    = rob_r;
  assign data.first  = f_val_r;
  assign data.second = s_val_r;
  assign data.writes = wr_r;
  assign data.dest   = dest_r;
  assign data.branch = br_r;
  assign data.pc     = pc_r;

endmodule

[design/reservation_station_unit.sv]
// Reservation station with ENTRIES slots, one cell per slot in a row; a
// priority chain running through the cells picks the lowest free slot on
// allocate and the lowest waiting slot when dispatched instructions are sent
// out. For allocate, broadcast and shift the command is applied to all cells
// at the input beat and the single result is loaded into the output register
// once it is free. Dispatch emits one result per ready slot (an empty one if
// none) into the output register, one slot per cycle unless the output
// stalls. in_tready is high only between items; output stalls hold the block.
`include "reservation_station_unit_macros.svh"

module reservation_station_unit #(
  parameter int ENTRIES = rsu_pkg::RSU_ENTRIES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_operand, first_ready, second_operand, second_ready, pc, rob_slot,
  // writes_reg, is_branch, dest_rename, bcast_tag, bcast_value
  input  logic [207:0] in_tdata,
  // command
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_rob_slot, out_first, out_second, out_writes, out_dest, out_branch,
  // out_pc, dropped, free_slots
  output logic [143:0] out_tdata,
  // is_dispatch
  output logic         out_tuser,
  output logic         out_tlast
);
  import rsu_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             drop_r, drop_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [143:0]     out_data_r, out_data_nxt;
  logic             out_user_r, out_user_nxt;
  logic             out_last_r, out_last_nxt;

  cell_ctl_t        ctl;
  logic [ENTRIES:0] chain;
  logic [ENTRIES-1:0] grant_vec;
  logic [ENTRIES-1:0] busy_vec;
  logic [ENTRIES-1:0] pend_vec;
  cell_st_t         cell_st [ENTRIES];
  slot_t            cell_data [ENTRIES];
  slot_t            sel;
  slot_t            res;

  logic             in_fire;
  logic             out_free;
  logic             emit_fire;
  logic             take;
  logic             is_disp;
  logic             last;
  logic [CW-1:0]    free_cnt;
  logic [CW+3:0]    free_ext;
  logic [W_FREE-1:0] free_slots;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    ctl.apply          = in_fire;
    ctl.cmd            = cmd_t'(in_tuser);
    ctl.emit_mode      = (state_r == S_EMIT);
    ctl.first_operand  = in_tdata[31:0];
    ctl.first_ready    = in_tdata[32];
    ctl.second_operand = in_tdata[64:33];
    ctl.second_ready   = in_tdata[65];
    ctl.pc             = in_tdata[97:66];
    ctl.rob_slot       = in_tdata[103:98];
    ctl.writes_reg     = in_tdata[104];
    ctl.is_branch      = in_tdata[105];
    ctl.dest_rename    = in_tdata[137:106];
    ctl.bcast_tag      = in_tdata[169:138];
    ctl.bcast_value    = in_tdata[201:170];
  end

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rsu_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .take      (take),
      .claim_in  (chain[i]),
      .claim_out (chain[i+1]),
      .grant     (grant_vec[i]),
      .st        (cell_st[i]),
      .data      (cell_data[i])
    );
    assign busy_vec[i] = cell_st[i].busy;
    assign pend_vec[i] = cell_st[i].pend;
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (grant_vec[i]) sel = slot_t'(sel | cell_data[i]);
    end
  end

  always_comb begin
    free_cnt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!busy_vec[i]) free_cnt = free_cnt + CW'(1);
    end
  end

  assign free_ext   = {4'b0000, free_cnt};
  assign free_slots = free_ext[W_FREE-1:0];

  assign is_disp = (cmd_r == CMD_DISP) && chain[ENTRIES];
  assign last    = !is_disp || ((pend_vec & ~grant_vec) == '0);
  assign res     = is_disp ? sel : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_fire && last) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    emit_fire = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_EMIT: begin
        emit_fire = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign take = emit_fire && (cmd_r == CMD_DISP);

  always_comb begin
    cmd_nxt  = cmd_r;
    drop_nxt = drop_r;
    if (in_fire) begin
      cmd_nxt  = ctl.cmd;
      drop_nxt = (ctl.cmd == CMD_ALLOC) && !chain[ENTRIES];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = is_disp;
      out_last_nxt  = last;
      out_data_nxt  = {2'b00, free_slots, drop_r && !is_disp, res.pc, res.branch,
                       res.dest, res.writes, res.second, res.first, res.rob};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    drop_r     <= drop_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `RSU_ASSERT_NOW(a_pend_not_busy, clk, rst_n, 1'b1, (pend_vec & busy_vec) == '0, "pending slot still busy")
  `RSU_ASSERT_NOW(a_grant_onehot, clk, rst_n, state_r == S_EMIT, $onehot0(grant_vec), "more than one slot granted")
  `RSU_ASSERT_NEXT(a_alloc_fills, clk, rst_n, in_fire && ctl.cmd == CMD_ALLOC && chain[ENTRIES], $countones(busy_vec) == $past($countones(busy_vec)) + 1, "allocate did not fill one slot")

endmodule

[tb/sv/reservation_station_unit_test.sv]
module reservation_station_unit_test;
  import rsu_pkg::*;

  // in_tdata layout, lowest bit first: first_operand, first_ready, second_operand,
  // second_ready, pc, rob_slot, writes_reg, is_branch, dest_rename, bcast_tag,
  // bcast_value, zero pad
  typedef struct packed {
    logic [5:0]          pad;
    logic [W_VAL-1:0]    bcast_value;
    logic [W_VAL-1:0]    bcast_tag;
    logic [W_VAL-1:0]    dest_rename;
    logic                is_branch;
    logic                writes_reg;
    logic [W_ROB_IN-1:0] rob_slot;
    logic [W_VAL-1:0]    pc;
    logic                second_ready;
    logic [W_VAL-1:0]    second_operand;
    logic                first_ready;
    logic [W_VAL-1:0]    first_operand;
  } op_fields_t;

  typedef struct packed {
    cmd_t       cmd;
    op_fields_t f;
  } rs_beat_t;

  // out_tdata layout, lowest bit first: out_rob_slot, out_first, out_second,
  // out_writes, out_dest, out_branch, out_pc, dropped, free_slots, zero pad
  typedef struct packed {
    logic [1:0]        pad;
    logic [W_FREE-1:0] free_slots;
    logic              dropped;
    logic [W_VAL-1:0]  pc;
    logic              branch;
    logic [W_VAL-1:0]  dest;
    logic              writes;
    logic [W_VAL-1:0]  second;
    logic [W_VAL-1:0]  first;
    logic [W_ROB-1:0]  rob;
  } res_fields_t;

  typedef struct packed {
    logic        is_dispatch;
    logic        last;
    res_fields_t f;
  } rs_result_t;

  typedef struct {
    bit             busy;
    bit             f_ok;
    bit             s_ok;
    bit [W_VAL-1:0] f_val;
    bit [W_VAL-1:0] s_val;
    bit [W_VAL-1:0] pc;
    bit [W_VAL-1:0] dest;
    bit [W_ROB-1:0] rob;
    bit             writes;
    bit             branch;
  } slot_rec_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [207:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  slot_rec_t  station [RSU_ENTRIES];
  rs_beat_t   stim_q [$];
  rs_result_t awaited_results [$];

  int  beats_offered = 0;
  int  beats_taken = 0;
  int  total_beats = 0;
  int  results_seen = 0;
  int  mismatch_cnt = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  int  hold_left = 0;
  bit  held_once = 0;
  bit  calm = 0;

  reservation_station_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void predict_station(cmd_t cmd, op_fields_t f);
    rs_result_t batch [$];
    rs_result_t r;
    bit         placed;
    int         free_cnt;
    r = '0;
    placed = 0;
    free_cnt = 0;
    case (cmd)
      CMD_ALLOC: begin
        for (int i = 0; i < RSU_ENTRIES; i++) begin
          if (!station[i].busy && !placed) begin
            placed = 1;
            station[i].busy = 1;
            station[i].f_val = f.first_operand;
            station[i].f_ok = f.first_ready;
            station[i].s_val = f.second_operand;
            station[i].s_ok = f.second_ready;
            station[i].pc = f.pc;
            station[i].rob = {1'b0, f.rob_slot};
            station[i].writes = f.writes_reg;
            station[i].branch = f.is_branch;
            station[i].dest = f.writes_reg ? f.dest_rename : '0;
          end
        end
        r.f.dropped = !placed;
        batch.push_back(r);
      end
      CMD_BCAST: begin
        for (int i = 0; i < RSU_ENTRIES; i++) begin
          if (station[i].busy) begin
            if (!station[i].f_ok && station[i].f_val == f.bcast_tag) begin
              station[i].f_val = f.bcast_value;
              station[i].f_ok = 1;
            end
            if (!station[i].s_ok && station[i].s_val == f.bcast_tag) begin
              station[i].s_val = f.bcast_value;
              station[i].s_ok = 1;
            end
          end
        end
        batch.push_back(r);
      end
      CMD_DISP: begin
        for (int i = 0; i < RSU_ENTRIES; i++) begin
          if (station[i].busy && station[i].f_ok && station[i].s_ok) begin
            r = '0;
            r.is_dispatch = 1;
            r.f.rob = station[i].rob;
            r.f.first = station[i].f_val;
            r.f.second = station[i].s_val;
            r.f.writes = station[i].writes;
            r.f.dest = station[i].dest;
            r.f.branch = station[i].branch;
            r.f.pc = station[i].pc;
            station[i].busy = 0;
            batch.push_back(r);
          end
        end
        if (batch.size() == 0) batch.push_back('0);
      end
      default: begin
        for (int i = 0; i < RSU_ENTRIES; i++) begin
          if (station[i].busy) begin
            station[i].rob = station[i].rob - 1'b1;
            station[i].dest = station[i].dest - 1;
            if (!station[i].f_ok) station[i].f_val = station[i].f_val - 1;
            if (!station[i].s_ok) station[i].s_val = station[i].s_val - 1;
          end
        end
        batch.push_back(r);
      end
    endcase
    for (int i = 0; i < RSU_ENTRIES; i++) if (!station[i].busy) free_cnt++;
    foreach (batch[k]) begin
      batch[k].f.free_slots = free_cnt[W_FREE-1:0];
      batch[k].last = (k == batch.size() - 1);
      awaited_results.push_back(batch[k]);
    end
  endfunction

  function automatic void compare_result(rs_result_t exp_r, rs_result_t got);
    bit bad;
    bad = 0;
    if (got.is_dispatch !== exp_r.is_dispatch) bad = 1;
    if (got.last !== exp_r.last) bad = 1;
    if (got.f.rob !== exp_r.f.rob) bad = 1;
    if (got.f.first !== exp_r.f.first) bad = 1;
    if (got.f.second !== exp_r.f.second) bad = 1;
    if (got.f.writes !== exp_r.f.writes) bad = 1;
    if (got.f.dest !== exp_r.f.dest) bad = 1;
    if (got.f.branch !== exp_r.f.branch) bad = 1;
    if (got.f.pc !== exp_r.f.pc) bad = 1;
    if (got.f.dropped !== exp_r.f.dropped) bad = 1;
    if (got.f.free_slots !== exp_r.f.free_slots) bad = 1;
    if (bad) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("mismatch exp: disp=%0d rob=%h a=%h b=%h w=%0d dst=%h br=%0d pc=%h drop=%0d free=%0d last=%0d",
                 exp_r.is_dispatch, exp_r.f.rob, exp_r.f.first, exp_r.f.second, exp_r.f.writes,
                 exp_r.f.dest, exp_r.f.branch, exp_r.f.pc, exp_r.f.dropped,
                 exp_r.f.free_slots, exp_r.last);
        $display("         got: disp=%0d rob=%h a=%h b=%h w=%0d dst=%h br=%0d pc=%h drop=%0d free=%0d last=%0d",
                 got.is_dispatch, got.f.rob, got.f.first, got.f.second, got.f.writes,
                 got.f.dest, got.f.branch, got.f.pc, got.f.dropped,
                 got.f.free_slots, got.last);
      end
    end
  endfunction

  function automatic logic [W_VAL-1:0] pick_tag();
    logic [W_VAL-1:0] t;
    if ($urandom_range(0, 9) == 0) t = $urandom;
    else t = $urandom_range(0, 23) - 8;
    return t;
  endfunction

  task automatic queue_alloc(logic [W_VAL-1:0] fo, logic fr, logic [W_VAL-1:0] so, logic sr,
                             logic [W_VAL-1:0] pc, logic [W_ROB_IN-1:0] rob, logic wr,
                             logic br, logic [W_VAL-1:0] dest);
    rs_beat_t b;
    b = '0;
    b.cmd = CMD_ALLOC;
    b.f.first_operand = fo;
    b.f.first_ready = fr;
    b.f.second_operand = so;
    b.f.second_ready = sr;
    b.f.pc = pc;
    b.f.rob_slot = rob;
    b.f.writes_reg = wr;
    b.f.is_branch = br;
    b.f.dest_rename = dest;
    stim_q.push_back(b);
  endtask

  task automatic queue_op(cmd_t c, logic [W_VAL-1:0] tag, logic [W_VAL-1:0] val);
    rs_beat_t b;
    b = '0;
    b.cmd = c;
    b.f.bcast_tag = tag;
    b.f.bcast_value = val;
    stim_q.push_back(b);
  endtask

  task automatic queue_random_alloc();
    logic fr;
    logic sr;
    fr = 1'($urandom_range(0, 1));
    sr = 1'($urandom_range(0, 1));
    queue_alloc(fr ? $urandom : pick_tag(), fr, sr ? $urandom : pick_tag(), sr, $urandom,
                W_ROB_IN'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), $urandom);
  endtask

  // sender: beats and idle bursts at the falling edge
  always @(negedge clk) begin : drive_beats
    rs_beat_t nb;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && beats_taken != beats_offered) begin
      in_tvalid <= 1'b1;
    end else if (send_gap > 0) begin
      in_tvalid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      send_gap <= $urandom_range(0, 4);
    end else if (stim_q.size() != 0) begin
      nb = stim_q.pop_front();
      in_tdata <= nb.f;
      in_tuser <= nb.cmd;
      in_tvalid <= 1'b1;
      beats_offered <= beats_offered + 1;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_station(cmd_t'(in_tuser), op_fields_t'(in_tdata));
      beats_taken <= beats_taken + 1;
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held_once && results_seen >= 20) begin
      out_tready <= 1'b0;
      held_once <= 1'b1;
      hold_left <= 150;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else if (recv_stall > 0) begin
      out_tready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      recv_stall <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_results
    rs_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      got.is_dispatch = out_tuser;
      got.last = out_tlast;
      got.f = out_tdata;
      if (awaited_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result beat: %h", out_tdata);
      end else begin
        compare_result(awaited_results.pop_front(), got);
      end
    end
  end

  initial begin
    // empty table
    queue_op(CMD_DISP, '0, '0);
    queue_op(CMD_SHIFT, '0, '0);
    queue_op(CMD_BCAST, 32'h0000_0005, 32'h1234_5678);
    // field extremes
    queue_alloc(32'h7FFF_FFFF, 1, 32'h8000_0000, 1, 32'hFFFF_FFFF, 6'd63, 1, 1, 32'h7FFF_FFFF);
    queue_alloc(32'd5, 0, 32'd5, 0, 32'h0, 6'd0, 0, 0, 32'hFFFF_FFFF);
    queue_alloc(32'h8000_0000, 0, 32'h0, 1, 32'h8000_0000, 6'd0, 1, 0, 32'h0);
    // wraparound on shift, then both operands woken by one tag
    queue_op(CMD_SHIFT, '0, '0);
    queue_op(CMD_BCAST, 32'd4, 32'hDEAD_BEEF);
    queue_op(CMD_DISP, '0, '0);
    queue_op(CMD_BCAST, 32'h7FFF_FFFF, 32'h8000_0000);
    // fill the table, then one allocate too many
    repeat (8) queue_alloc($urandom, 1, 32'd1, 0, $urandom, W_ROB_IN'($urandom_range(0, 63)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
    queue_op(CMD_BCAST, 32'd1, 32'hFFFF_FFFF);
    queue_op(CMD_DISP, '0, '0);
    repeat (110) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: queue_random_alloc();
        8, 9, 10, 11, 12: queue_op(CMD_BCAST, pick_tag(), $urandom);
        13, 14, 15, 16: queue_op(CMD_DISP, $urandom, $urandom);
        default: queue_op(CMD_SHIFT, $urandom, $urandom);
      endcase
    end
    total_beats = stim_q.size();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (stim_q.size() > 25) @(posedge clk);
    calm = 1;
    while (beats_taken != total_beats) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
